[src/clt_pkg.sv]
// Shared types, character codes and widths for the CNF literal tokenizer.
package clt_pkg;

   localparam int VAR_BITS   = 24;
   localparam int VAR_W      = 24;
   localparam int ACC_W      = VAR_BITS + 4;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_P     = 8'h70;

   typedef enum logic [2:0] {
      PH_HDR  = 3'd0,
      PH_HDRC = 3'd1,
      PH_HDRP = 3'd2,
      PH_BODY = 3'd3,
      PH_BCOM = 3'd4,
      PH_SIGN = 3'd5,
      PH_DIG  = 3'd6,
      PH_STOP = 3'd7
   } clt_phase_type;

   typedef enum logic [1:0] {
      KIND_LIT  = 2'd0,
      KIND_CEND = 2'd1,
      KIND_DONE = 2'd2,
      KIND_ERR  = 2'd3
   } clt_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_SYNTAX   = 2'd1,
      ERR_OVERFLOW = 2'd2
   } clt_err_type;

   typedef struct packed {
      clt_kind_type       kind;
      logic [VAR_W-1:0]   var_number;
      logic               negative;
      logic [VAR_W-1:0]   largest_var;
      logic               header_seen;
      clt_err_type        error_code;
      logic               last;
   } clt_result_type;

   typedef struct packed {
      logic [1:0]     count;
      clt_result_type first;
      clt_result_type second;
   } clt_push_type;

   function automatic clt_result_type clt_make_tok(clt_kind_type k,
                                                   logic [VAR_W-1:0] v,
                                                   logic neg,
                                                   clt_err_type e);
      clt_result_type r;
      r.kind        = k;
      r.var_number  = v;
      r.negative    = neg;
      r.largest_var = '0;
      r.header_seen = 1'b0;
      r.error_code  = e;
      r.last        = 1'b0;
      return r;
   endfunction

endpackage

[src/clt_lexer.sv]
// Input beat register, tokenizer state and single-pass decode of one byte.
module clt_lexer
   import clt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_text_byte,
   input  logic                req_end_of_input,
   input  logic                room,
   output clt_push_type        push
);

   logic                in_vld_ff, in_vld_in;
   logic [7:0]          in_byte_ff;
   logic                in_eof_ff;
   logic                take;

   clt_phase_type       phase_ff, phase_in;
   logic                inside_ff, inside_in;
   logic [VAR_BITS-1:0] val_ff, val_in;
   logic                neg_ff, neg_in;
   logic [VAR_BITS-1:0] large_ff, large_in;
   logic                hdr_ff, hdr_in;

   logic                is_sp, is_dig, eof;
   logic [3:0]          dig_val;
   logic [ACC_W-1:0]    acc;
   logic                over;
   logic                body_go;
   logic                tok1_v, tok2_v;
   clt_result_type      tok1, tok2;
   clt_result_type      res_a, res_b;

   assign req_stall = in_vld_ff && !room;
   assign take      = in_vld_ff && room;
   assign in_vld_in = req_stall ? in_vld_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_text_byte;
         in_eof_ff  <= req_end_of_input;
      end
   end

   assign eof     = in_eof_ff;
   assign is_sp   = (in_byte_ff >= CH_TAB && in_byte_ff <= CH_CR) || in_byte_ff == CH_SPACE;
   assign is_dig  = in_byte_ff >= CH_ZERO && in_byte_ff <= CH_NINE;
   assign dig_val = 4'(in_byte_ff - CH_ZERO);
   assign acc     = (ACC_W'(val_ff) << 3) + (ACC_W'(val_ff) << 1) + ACC_W'(dig_val);
   assign over    = acc[ACC_W-1:VAR_BITS] != '0;

   always_comb begin
      phase_in  = phase_ff;
      inside_in = inside_ff;
      val_in    = val_ff;
      neg_in    = neg_ff;
      large_in  = large_ff;
      hdr_in    = hdr_ff;
      body_go   = 1'b0;
      tok1_v    = 1'b0;
      tok2_v    = 1'b0;
      tok1      = clt_make_tok(KIND_LIT, '0, 1'b0, ERR_NONE);
      tok2      = clt_make_tok(KIND_LIT, '0, 1'b0, ERR_NONE);

      unique case (phase_ff)
         PH_HDR: begin
            if (eof) begin
               tok2_v   = 1'b1;
               tok2     = clt_make_tok(KIND_DONE, '0, 1'b0, ERR_NONE);
               phase_in = PH_STOP;
            end else if (in_byte_ff == CH_C) begin
               phase_in = PH_HDRC;
            end else if (in_byte_ff == CH_P) begin
               hdr_in   = 1'b1;
               phase_in = PH_HDRP;
            end else begin
               body_go = 1'b1;
            end
         end
         PH_HDRC, PH_HDRP, PH_BCOM: begin
            if (eof) begin
               tok2_v   = 1'b1;
               tok2     = clt_make_tok(KIND_DONE, '0, 1'b0, ERR_NONE);
               phase_in = PH_STOP;
            end else if (in_byte_ff == CH_LF) begin
               phase_in = (phase_ff == PH_HDRC) ? PH_HDR : PH_BODY;
            end
         end
         PH_BODY: begin
            body_go = 1'b1;
         end
         PH_SIGN: begin
            if (!eof && is_dig) begin
               val_in   = VAR_BITS'(dig_val);
               phase_in = PH_DIG;
            end else begin
               tok2_v   = 1'b1;
               tok2     = clt_make_tok(KIND_ERR, '0, 1'b0, ERR_SYNTAX);
               phase_in = PH_STOP;
            end
         end
         PH_DIG: begin
            if (!eof && is_dig) begin
               if (over) begin
                  tok2_v   = 1'b1;
                  tok2     = clt_make_tok(KIND_ERR, '0, 1'b0, ERR_OVERFLOW);
                  phase_in = PH_STOP;
               end else begin
                  val_in = acc[VAR_BITS-1:0];
               end
            end else begin
               tok1_v = 1'b1;
               if (val_ff == '0) begin
                  inside_in = 1'b0;
                  tok1      = clt_make_tok(KIND_CEND, '0, 1'b0, ERR_NONE);
               end else begin
                  if (val_ff > large_ff) begin
                     large_in = val_ff;
                  end
                  tok1 = clt_make_tok(KIND_LIT, VAR_W'(val_ff), neg_ff, ERR_NONE);
               end
               val_in  = '0;
               neg_in  = 1'b0;
               body_go = 1'b1;
            end
         end
         PH_STOP: begin
            phase_in = PH_STOP;
         end
         default: begin
            phase_in = PH_STOP;
         end
      endcase

      if (body_go) begin
         phase_in = PH_BODY;
         if (!eof && is_sp) begin
            phase_in = PH_BODY;
         end else if (eof) begin
            tok2_v   = 1'b1;
            tok2     = inside_in ? clt_make_tok(KIND_ERR, '0, 1'b0, ERR_SYNTAX)
                                 : clt_make_tok(KIND_DONE, '0, 1'b0, ERR_NONE);
            phase_in = PH_STOP;
         end else if (!inside_in && in_byte_ff == CH_C) begin
            phase_in = PH_BCOM;
         end else begin
            inside_in = 1'b1;
            priority if (in_byte_ff == CH_MINUS) begin
               neg_in   = 1'b1;
               phase_in = PH_SIGN;
            end else if (in_byte_ff == CH_PLUS) begin
               neg_in   = 1'b0;
               phase_in = PH_SIGN;
            end else if (is_dig) begin
               neg_in   = 1'b0;
               val_in   = VAR_BITS'(dig_val);
               phase_in = PH_DIG;
            end else begin
               tok2_v   = 1'b1;
               tok2     = clt_make_tok(KIND_ERR, '0, 1'b0, ERR_SYNTAX);
               phase_in = PH_STOP;
            end
         end
      end

      res_a             = tok1_v ? tok1 : tok2;
      res_b             = tok2;
      res_a.largest_var = VAR_W'(large_in);
      res_a.header_seen = hdr_in;
      res_a.last        = !(tok1_v && tok2_v);
      res_b.largest_var = VAR_W'(large_in);
      res_b.header_seen = hdr_in;
      res_b.last        = 1'b1;
   end

   assign push.count  = take ? (2'(tok1_v) + 2'(tok2_v)) : 2'd0;
   assign push.first  = res_a;
   assign push.second = res_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR;
         inside_ff <= 1'b0;
         val_ff    <= '0;
         neg_ff    <= 1'b0;
         large_ff  <= '0;
         hdr_ff    <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         inside_ff <= inside_in;
         val_ff    <= val_in;
         neg_ff    <= neg_in;
         large_ff  <= large_in;
         hdr_ff    <= hdr_in;
      end
   end

`ifndef SYNTHESIS
   a_stop_holds: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_STOP |=> phase_ff == PH_STOP)
      else $error("tokenizer left the stopped phase");

   a_pair_ends: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |->
         (push.second.kind == KIND_DONE || push.second.kind == KIND_ERR))
      else $error("second result of a beat is not a finish or an error");

   a_largest_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> large_ff >= $past(large_ff))
      else $error("largest variable decreased");
`endif

endmodule

[src/clt_rsp_fifo.sv]
// Result queue that takes up to two results per cycle and sends one per beat.
module clt_rsp_fifo
   import clt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  clt_push_type   push,
   output logic           room,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output clt_result_type head
);

   clt_result_type       mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ff, wr_in;
   logic [FIFO_AW-1:0]   rd_ff, rd_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 pop;

   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign room      = count_ff <= FIFO_CW'(FIFO_DEPTH - 2);
   assign head      = mem[rd_ff];

   assign wr_in    = wr_ff + FIFO_AW'(push.count);
   assign rd_in    = rd_ff + FIFO_AW'(pop);
   assign count_in = count_ff + FIFO_CW'(push.count) - FIFO_CW'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_ff + FIFO_AW'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CW'(FIFO_DEPTH))
      else $error("result queue count out of range");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("results pushed without room");

   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      pop && !head.last |=> count_ff != '0)
      else $error("first result of a pair sent without its partner queued");
`endif

endmodule

[src/cnf_literal_tokenizer_core.sv]
// Top level of the CNF literal tokenizer: byte decode and result queue.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  text_byte, end_of_input
//   rsp      out        rsp_valid/rsp_stall  kind, var_number, negative, largest_var,
//                                            header_seen, error_code, last
//
// One byte beat is taken every cycle while req_stall is low; a byte decodes
// combinationally between the input register and the result queue.
// Results leave the queue once their byte has passed the input register and been written
// to the queue memory; a byte that yields two results sends them on two rsp beats.
// req_stall rises only when the queue has fewer than two free slots.
// Synchronous active-high reset returns the tokenizer to the header area.
module cnf_literal_tokenizer_core
   import clt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_text_byte,
   input  logic             req_end_of_input,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [VAR_W-1:0] rsp_var_number,
   output logic             rsp_negative,
   output logic [VAR_W-1:0] rsp_largest_var,
   output logic             rsp_header_seen,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_last
);

   clt_push_type   push;
   logic           room;
   clt_result_type head;

   clt_lexer u_lexer (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_end_of_input (req_end_of_input),
      .room             (room),
      .push             (push)
   );

   clt_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_kind        = head.kind;
   assign rsp_var_number  = head.var_number;
   assign rsp_negative    = head.negative;
   assign rsp_largest_var = head.largest_var;
   assign rsp_header_seen = head.header_seen;
   assign rsp_error_code  = head.error_code;
   assign rsp_last        = head.last;

endmodule
